/* src/slefr_pkg.sv */
// Shared types and constants for the sync/length/end frame receiver.
// Depends on nothing; imported by the receiver and its checker.
package slefr_pkg;

    // Framing bytes and fixed overhead (two sync, two length, one end byte)
    localparam logic [7:0] SYNC_A   = 8'hA5;
    localparam logic [7:0] SYNC_B   = 8'h5A;
    localparam logic [7:0] END_MARK = 8'h96;
    localparam int unsigned OVERHEAD = 5;

    // Configuration registers
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = 1'd1;
    localparam logic [15:0] TIMEOUT_RESET = 16'd300;
    localparam logic [11:0] MAX_LEN_RESET = 12'd2048;

    // Input item kinds
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_IDLE = 1'b1;

    // Receiver phases
    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_LEN1  = 3'd2,
        PH_LEN2  = 3'd3,
        PH_DATA  = 3'd4,
        PH_END   = 3'd5
    } phase_t;

    // Result event codes
    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_TAKEN   = 3'd1,
        EV_DONE    = 3'd2,
        EV_BADLEN  = 3'd3,
        EV_BADEND  = 3'd4,
        EV_TIMEOUT = 3'd5
    } event_t;

    // Input transaction payload
    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } in_item_t;

    // Result transaction payload
    typedef struct packed {
        logic [2:0]  event_res;
        logic        store_byte;
        logic [10:0] byte_index;
        logic [7:0]  byte_value;
        logic [15:0] frame_length;
    } out_item_t;

endpackage

/* src/sync_length_end_frame_receiver.sv */
// Top level of the sync/length/end frame receiver: framing state machine
// and result register. Depends on slefr_pkg.
//
// The receiver takes one transaction per clock while s_ready is high, either a
// received byte or an idle tick, and gives exactly one result transaction for
// each. Each result appears in the cycle after its input is taken and sits in
// the output register until m_ready; s_ready stays high while that register is
// empty or being drained, so a stream with m_ready held high runs at one item
// per clock and the output register alone sets that rate. It hunts for A5 5A,
// reads a little-endian total length, rejects lengths below 5 or above the
// smaller of max_frame_length and MAX_FRAME, passes the payload and checks the
// 0x96 end byte. Every byte belonging to a frame is reported with its buffer
// index (low 11 bits of the position). Idle ticks outside hunting count toward
// timeout_ticks. Configuration must be written by the user only while no
// transaction is in flight, through cfg_wr_en/cfg_index/cfg_wdata; not enforced.
module sync_length_end_frame_receiver #(
    parameter int unsigned MAX_FRAME = 2048
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  slefr_pkg::in_item_t                  s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output slefr_pkg::out_item_t                 m_data,
    input  logic                                 cfg_wr_en,
    input  logic [slefr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [slefr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import slefr_pkg::*;

    // Longest length that can pass both limits (max_frame_length is 12 bits)
    localparam int unsigned LEN_CAP = (MAX_FRAME < 4095) ? MAX_FRAME : 4095;
    localparam int unsigned CNT_W   = $clog2(LEN_CAP);
    localparam int unsigned SUM_W   = CNT_W + 2;

    logic [15:0]      timeout_ticks_reg;
    logic [11:0]      max_len_reg;
    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] pexp_reg, pexp_next;
    logic [CNT_W-1:0] pcnt_reg, pcnt_next;
    logic [15:0]      length_reg, length_next;
    logic [15:0]      idle_reg, idle_next;
    logic             m_valid_reg;
    out_item_t        m_data_reg, m_data_next;

    logic             accept;
    logic [15:0]      idle_inc;
    logic             timeout_hit;
    logic [15:0]      len_full;
    logic             len_bad;
    logic [CNT_W-1:0] len_pay;
    logic [CNT_W-1:0] pcnt_inc;
    logic [SUM_W-1:0] data_pos;
    logic [SUM_W-1:0] end_pos;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Shared decision terms
    assign idle_inc    = idle_reg + 16'd1;
    assign timeout_hit = (idle_inc >= timeout_ticks_reg);
    assign len_full    = {s_data.rx_byte, length_reg[7:0]};
    assign len_bad     = (len_full < 16'(OVERHEAD)) || (len_full > {4'd0, max_len_reg})
                         || ({1'b0, len_full} > 17'(MAX_FRAME));
    assign len_pay     = CNT_W'(len_full - 16'(OVERHEAD));
    assign pcnt_inc    = pcnt_reg + CNT_W'(1);
    assign data_pos    = SUM_W'(pcnt_inc) + SUM_W'(3);
    assign end_pos     = SUM_W'(pcnt_reg) + SUM_W'(4);

    // Next state and counters
    always_comb begin
        phase_next  = phase_reg;
        pexp_next   = pexp_reg;
        pcnt_next   = pcnt_reg;
        length_next = length_reg;
        idle_next   = idle_reg;
        if (s_data.func == FUNC_IDLE) begin
            if (phase_reg == PH_HUNT1) begin
                idle_next = 16'd0;
            end else if (timeout_hit) begin
                idle_next  = 16'd0;
                phase_next = PH_HUNT1;
            end else begin
                idle_next = idle_inc;
            end
        end else begin
            case (phase_reg)
                PH_HUNT1: begin
                    if (s_data.rx_byte == SYNC_A) phase_next = PH_HUNT2;
                end
                PH_HUNT2: begin
                    phase_next = (s_data.rx_byte == SYNC_B) ? PH_LEN1 : PH_HUNT1;
                end
                PH_LEN1: begin
                    length_next = {8'd0, s_data.rx_byte};
                    phase_next  = PH_LEN2;
                end
                PH_LEN2: begin
                    length_next = len_full;
                    if (len_bad) begin
                        phase_next = PH_HUNT1;
                    end else begin
                        pexp_next  = len_pay;
                        pcnt_next  = '0;
                        phase_next = (len_pay == '0) ? PH_END : PH_DATA;
                    end
                end
                PH_DATA: begin
                    pcnt_next = pcnt_inc;
                    if (pcnt_inc >= pexp_reg) phase_next = PH_END;
                end
                PH_END: begin
                    phase_next = PH_HUNT1;
                    if (s_data.rx_byte == END_MARK) idle_next = 16'd0;
                end
                default: begin
                    phase_next = PH_HUNT1;
                end
            endcase
        end
    end

    // Result fields
    always_comb begin
        m_data_next              = '0;
        m_data_next.frame_length = length_next;
        if (s_data.func == FUNC_IDLE) begin
            if (phase_reg != PH_HUNT1 && timeout_hit) m_data_next.event_res = EV_TIMEOUT;
        end else begin
            case (phase_reg)
                PH_HUNT1: begin
                    if (s_data.rx_byte == SYNC_A) begin
                        m_data_next.event_res  = EV_TAKEN;
                        m_data_next.store_byte = 1'b1;
                        m_data_next.byte_index = 11'd0;
                    end
                end
                PH_HUNT2: begin
                    if (s_data.rx_byte == SYNC_B) begin
                        m_data_next.event_res  = EV_TAKEN;
                        m_data_next.store_byte = 1'b1;
                        m_data_next.byte_index = 11'd1;
                    end
                end
                PH_LEN1: begin
                    m_data_next.event_res  = EV_TAKEN;
                    m_data_next.store_byte = 1'b1;
                    m_data_next.byte_index = 11'd2;
                end
                PH_LEN2: begin
                    if (len_bad) begin
                        m_data_next.event_res = EV_BADLEN;
                    end else begin
                        m_data_next.event_res  = EV_TAKEN;
                        m_data_next.store_byte = 1'b1;
                        m_data_next.byte_index = 11'd3;
                    end
                end
                PH_DATA: begin
                    m_data_next.event_res  = EV_TAKEN;
                    m_data_next.store_byte = 1'b1;
                    m_data_next.byte_index = 11'(data_pos);
                end
                PH_END: begin
                    m_data_next.event_res  = (s_data.rx_byte == END_MARK) ? EV_DONE : EV_BADEND;
                    m_data_next.store_byte = 1'b1;
                    m_data_next.byte_index = 11'(end_pos);
                end
                default: begin
                    m_data_next.event_res = EV_NONE;
                end
            endcase
            if (m_data_next.store_byte) m_data_next.byte_value = s_data.rx_byte;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_ticks_reg <= TIMEOUT_RESET;
            max_len_reg       <= MAX_LEN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_wdata[15:0];
                CFG_MAX_FRAME_LEN: max_len_reg       <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // Advance framing state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT1;
            pexp_reg   <= '0;
            pcnt_reg   <= '0;
            length_reg <= 16'd0;
            idle_reg   <= 16'd0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            pexp_reg   <= pexp_next;
            pcnt_reg   <= pcnt_next;
            length_reg <= length_next;
            idle_reg   <= idle_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

/* src/slefr_checker.sv */
// Port-level checks for the sync/length/end frame receiver, with the bind
// that attaches them to the top level. Depends on slefr_pkg.
module slefr_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input slefr_pkg::out_item_t  m_data
);
    import slefr_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Byte fields are zero unless a byte is stored
    a_no_store_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.store_byte |-> m_data.byte_index == 11'd0
                                         && m_data.byte_value == 8'd0)
        else $error("byte fields set without a store");

    // Store flag agrees with the event code
    a_store_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.store_byte == (m_data.event_res == EV_TAKEN
                                          || m_data.event_res == EV_DONE
                                          || m_data.event_res == EV_BADEND))
        else $error("store flag disagrees with event");

    // A complete frame ends on the end mark
    a_done_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_res == EV_DONE |-> m_data.byte_value == END_MARK)
        else $error("frame complete without end mark");

    // A stored byte in buffer slot zero is the first sync byte
    a_sync_slots: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_res == EV_TAKEN && m_data.byte_index == 11'd0
        |-> m_data.byte_value == SYNC_A)
        else $error("slot zero holds a non-sync byte");

endmodule

bind sync_length_end_frame_receiver slefr_checker u_slefr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Testbench for sync_length_end_frame_receiver: feeds framed byte and idle-tick
// traffic through the valid/ready channels and checks each result transaction
// against an in-bench prediction of the framing state machine. Needs slefr_pkg.
module testbench;
    import slefr_pkg::*;

    localparam int unsigned MAX_FRAME   = 2048;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned LONG_HOLD   = 300;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_TIMEOUT_TICKS;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Bytes and ticks waiting to be offered, and results still owed
    in_item_t  pending_items[$];
    out_item_t expected_results[$];

    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned hold_requests      = 0;
    int unsigned holds_served       = 0;
    int unsigned hold_left          = 0;
    int unsigned mismatch_count     = 0;
    int unsigned cycle_count        = 0;
    int unsigned stim_count         = 0;

    // Predicted receiver state and register copies
    logic [15:0] cfg_timeout   = TIMEOUT_RESET;
    logic [11:0] cfg_max_len   = MAX_LEN_RESET;
    phase_t      rx_phase      = PH_HUNT1;
    logic [10:0] payload_total = '0;
    logic [10:0] payload_seen  = '0;
    logic [15:0] length_field  = '0;
    logic [15:0] idle_ticks    = '0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    sync_length_end_frame_receiver #(
        .MAX_FRAME(MAX_FRAME)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // Advance the predicted framer by one byte or idle tick
    function automatic out_item_t frame_step(in_item_t item);
        out_item_t   res;
        event_t      ev;
        logic        store;
        logic [10:0] pos;
        res   = '0;
        ev    = EV_NONE;
        store = 1'b0;
        pos   = '0;
        if (item.func == FUNC_IDLE) begin
            if (rx_phase == PH_HUNT1) begin
                idle_ticks = '0;
            end else begin
                idle_ticks = idle_ticks + 16'd1;
                if (idle_ticks >= cfg_timeout) begin
                    idle_ticks = '0;
                    rx_phase   = PH_HUNT1;
                    ev         = EV_TIMEOUT;
                end
            end
        end else begin
            case (rx_phase)
                PH_HUNT1: begin
                    if (item.rx_byte == SYNC_A) begin
                        rx_phase = PH_HUNT2;
                        ev       = EV_TAKEN;
                        store    = 1'b1;
                        pos      = 11'd0;
                    end
                end
                PH_HUNT2: begin
                    // a failed second sync byte is not retried as a first one
                    if (item.rx_byte == SYNC_B) begin
                        rx_phase = PH_LEN1;
                        ev       = EV_TAKEN;
                        store    = 1'b1;
                        pos      = 11'd1;
                    end else begin
                        rx_phase = PH_HUNT1;
                    end
                end
                PH_LEN1: begin
                    length_field = {8'h00, item.rx_byte};
                    rx_phase     = PH_LEN2;
                    ev           = EV_TAKEN;
                    store        = 1'b1;
                    pos          = 11'd2;
                end
                PH_LEN2: begin
                    length_field = {item.rx_byte, length_field[7:0]};
                    if (length_field < OVERHEAD || length_field > cfg_max_len ||
                        length_field > MAX_FRAME) begin
                        rx_phase = PH_HUNT1;
                        ev       = EV_BADLEN;
                    end else begin
                        payload_total = 11'(length_field - OVERHEAD);
                        payload_seen  = '0;
                        rx_phase      = (payload_total == 11'd0) ? PH_END : PH_DATA;
                        ev            = EV_TAKEN;
                        store         = 1'b1;
                        pos           = 11'd3;
                    end
                end
                PH_DATA: begin
                    payload_seen = payload_seen + 11'd1;
                    pos          = payload_seen + 11'd3;
                    if (payload_seen >= payload_total) begin
                        rx_phase = PH_END;
                    end
                    ev    = EV_TAKEN;
                    store = 1'b1;
                end
                PH_END: begin
                    pos      = payload_seen + 11'd4;
                    rx_phase = PH_HUNT1;
                    store    = 1'b1;
                    if (item.rx_byte == END_MARK) begin
                        idle_ticks = '0;
                        ev         = EV_DONE;
                    end else begin
                        ev = EV_BADEND;
                    end
                end
                default: rx_phase = PH_HUNT1;
            endcase
        end
        res.event_res    = ev;
        res.store_byte   = store;
        res.byte_index   = store ? pos : 11'd0;
        res.byte_value   = store ? item.rx_byte : 8'd0;
        res.frame_length = length_field;
        return res;
    endfunction

    function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            mismatch_count++;
        end
    endfunction

    // Input driver: predict each accepted transaction, then offer the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(frame_step(s_data));
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    s_data  <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare against the oldest prediction, drive back-pressure
    always @(posedge aclk) begin : result_monitor
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with none expected: %p", m_data);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("event_res", 16'(want.event_res), 16'(m_data.event_res));
                    check_field("store_byte", 16'(want.store_byte), 16'(m_data.store_byte));
                    check_field("byte_index", 16'(want.byte_index), 16'(m_data.byte_index));
                    check_field("byte_value", 16'(want.byte_value), 16'(m_data.byte_value));
                    check_field("frame_length", want.frame_length, m_data.frame_length);
                end
            end
            // hold off for a long stretch when asked, else stall at random
            if (hold_left == 0 && holds_served != hold_requests) begin
                hold_left = LONG_HOLD;
                holds_served++;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic add_byte(logic [7:0] b);
        pending_items.push_back('{func: FUNC_BYTE, rx_byte: b});
        stim_count++;
    endtask

    task automatic add_idle();
        pending_items.push_back('{func: FUNC_IDLE, rx_byte: 8'($urandom)});
        stim_count++;
    endtask

    task automatic add_header(logic [15:0] total);
        add_byte(SYNC_A);
        add_byte(SYNC_B);
        add_byte(total[7:0]);
        add_byte(total[15:8]);
    endtask

    // Whole frame with random payload and idle ticks sprinkled in
    task automatic add_frame(int unsigned total, bit good_end, int unsigned gap_pct);
        int unsigned k;
        logic [7:0]  tail;
        add_header(16'(total));
        for (k = 0; k + OVERHEAD < total; k++) begin
            if ($urandom_range(99) < gap_pct) begin
                add_idle();
            end
            add_byte(8'($urandom));
        end
        tail = 8'($urandom);
        if (tail == END_MARK) begin
            tail = ~tail;
        end
        add_byte(good_end ? END_MARK : tail);
    endtask

    // Mostly well-formed frames, plus bad lengths, noise, broken sync and frames cut short
    task automatic add_random_traffic(int unsigned target, int unsigned gap_pct);
        int unsigned start_count, pick, span, len, k, n;
        logic [7:0]  b;
        start_count = stim_count;
        span        = (cfg_max_len < 40) ? cfg_max_len : 40;
        while (stim_count - start_count < target) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                // frames at the length limit only while that limit is short
                len = ($urandom_range(9) == 0 && cfg_max_len <= 64) ? cfg_max_len
                                                                    : $urandom_range(span, OVERHEAD);
                add_frame(len, $urandom_range(99) < 85, gap_pct);
            end else if (pick < 72) begin
                case ($urandom_range(3))
                    0:       len = $urandom_range(OVERHEAD - 1, 0);
                    1:       len = cfg_max_len + 1;
                    2:       len = 16'hFFFF;
                    default: len = $urandom_range(16'hFFFF, cfg_max_len + 1);
                endcase
                add_header(16'(len));
            end else if (pick < 84) begin
                // line noise and idle ticks while hunting
                n = $urandom_range(4, 1);
                for (k = 0; k < n; k++) begin
                    case ($urandom_range(3))
                        0:       pending_items.push_back('{func: FUNC_IDLE,
                                                           rx_byte: 8'($urandom)});
                        1:       pending_items.push_back('{func: FUNC_BYTE, rx_byte: SYNC_B});
                        default: pending_items.push_back('{func: FUNC_BYTE,
                                                           rx_byte: 8'($urandom)});
                    endcase
                end
                stim_count += n;
            end else if (pick < 92) begin
                add_byte(SYNC_A);
                if ($urandom_range(1) == 0) begin
                    // repeated first sync byte, then the second one
                    add_byte(SYNC_A);
                    add_byte(SYNC_B);
                end else begin
                    b = 8'($urandom);
                    if (b == SYNC_B) begin
                        b = ~b;
                    end
                    add_byte(b);
                end
            end else begin
                // frame cut short, followed by a run of idle ticks
                len = $urandom_range(span, OVERHEAD);
                add_header(16'(len));
                n = $urandom_range(len - OVERHEAD, 0);
                for (k = 0; k < n; k++) begin
                    add_byte(8'($urandom));
                end
                n = $urandom_range(8, 1);
                for (k = 0; k < n; k++) begin
                    add_idle();
                end
            end
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == CFG_TIMEOUT_TICKS) begin
            cfg_timeout = value;
        end else begin
            cfg_max_len = value[11:0];
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(int unsigned send_pct, int unsigned stall_pct);
        @(negedge aclk);
        sender_idle_pct    = send_pct;
        receiver_stall_pct = stall_pct;
    endtask

    // Hold until every transaction is through and the result register is empty
    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (3) @(posedge aclk);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed cases under the reset register values
        set_idling(0, 0);
        add_idle();
        add_header(16'd5);
        add_byte(END_MARK);
        add_byte(8'h00);
        add_byte(SYNC_A);
        add_byte(8'h13);
        add_header(16'd4);
        add_header(16'd2049);
        add_header(16'd6);
        add_byte(8'hFF);
        add_idle();
        add_byte(8'h00);
        wait_drained();

        // Long frame at the length limit, timeout out of reach, sender idling
        write_reg(CFG_TIMEOUT_TICKS, 16'hFFFF);
        write_reg(CFG_MAX_FRAME_LEN, 16'd160);
        set_idling(62, 0);
        add_frame(160, 1'b1, 0);
        add_random_traffic(80, 3);
        wait_drained();

        // Shortest timeout and frame limit, receiver stalling
        write_reg(CFG_TIMEOUT_TICKS, 16'd1);
        write_reg(CFG_MAX_FRAME_LEN, 16'd5);
        set_idling(0, 62);
        add_random_traffic(100, 5);
        wait_drained();

        write_reg(CFG_TIMEOUT_TICKS, 16'd3);
        write_reg(CFG_MAX_FRAME_LEN, 16'd17);
        set_idling(23, 23);
        add_random_traffic(100, 8);
        wait_drained();

        // Random settings, full rate, then a long receiver hold to fill the block
        write_reg(CFG_TIMEOUT_TICKS, 16'($urandom_range(40, 2)));
        write_reg(CFG_MAX_FRAME_LEN, 16'($urandom_range(60, 5)));
        set_idling(0, 0);
        add_random_traffic(100, 4);
        hold_requests++;
        wait_drained();

        write_reg(CFG_TIMEOUT_TICKS, 16'd300);
        write_reg(CFG_MAX_FRAME_LEN, 16'd2048);
        set_idling(23, 23);
        add_random_traffic(100, 2);
        wait_drained();

        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
